### hdl/assert_macros.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

### hdl/chq_pkg.sv
package chq_pkg;

  localparam int KIND_W   = 1;
  localparam int QSEL_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_PUT = 1'b0;
  localparam logic [KIND_W-1:0] KIND_GET = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOSPACE = 2'd2
  } status_t;

endpackage

### hdl/chq_char_mem.sv
module chq_char_mem #(
  parameter int DEPTH = 384,
  parameter int AW    = 9
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [chq_pkg::BYTE_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [chq_pkg::BYTE_W-1:0] wr_data
);
  import chq_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/chq_link_mem.sv
`include "assert_macros.svh"

module chq_link_mem #(
  parameter int NUM_BLOCKS = 64,
  parameter int BW         = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [BW-1:0] rd_addr,
  output logic [BW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [BW-1:0] wr_addr,
  input  logic [BW-1:0] wr_data,
  output logic          init_done
);

  localparam logic [BW-1:0] LAST_BLK = BW'(NUM_BLOCKS - 1);

  logic [BW-1:0] mem [NUM_BLOCKS];
  logic [BW-1:0] rd_data_r;
  logic [BW-1:0] init_cnt_r, init_cnt_nxt;
  logic          init_done_r, init_done_nxt;
  logic [BW-1:0] init_link;

  // after reset, chain every block to the next one as the free list
  assign init_link = (init_cnt_r == LAST_BLK) ? '0 : init_cnt_r + BW'(1);

  always_comb begin
    init_cnt_nxt  = init_cnt_r;
    init_done_nxt = init_done_r;
    if (!init_done_r) begin
      init_cnt_nxt = init_link;
      if (init_cnt_r == LAST_BLK) begin
        init_done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      init_done_r <= 1'b0;
    end else begin
      init_cnt_r  <= init_cnt_nxt;
      init_done_r <= init_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      mem[init_cnt_r] <= init_link;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign init_done = init_done_r;

  `ASSERT_NEVER(a_no_write_during_init, !init_done_r && wr_en, "link write during init sweep")
  `ASSERT_NEVER(a_no_read_during_init, !init_done_r && rd_en, "link read during init sweep")

endmodule

### hdl/linked_block_char_queue.sv
// Character queues on a shared pool of linked blocks. Each put or get is one
// transaction in and one result transaction out. An accepted transaction reads the
// link memory (and, for a get, the character memory) in the cycle it is accepted,
// moving from S_IDLE to S_EXEC; in S_EXEC it is resolved, when the memories are
// written as needed and the result register is loaded, and the next one can be
// accepted once the block is back in S_IDLE. S_EXEC waits while the previous result
// has not been taken. After reset the link memory is swept once to build the free
// list, during which in_ready stays low.
`include "assert_macros.svh"

module linked_block_char_queue #(
  parameter int NUM_QUEUES  = 4,
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_CHARS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [chq_pkg::KIND_W-1:0]    in_kind,
  input  logic [chq_pkg::QSEL_W-1:0]    in_queue_select,
  input  logic [chq_pkg::BYTE_W-1:0]    in_put_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [chq_pkg::BYTE_W-1:0]    out_got_byte,
  output logic [chq_pkg::STATUS_W-1:0]  out_status,
  output logic [chq_pkg::COUNT_W-1:0]   out_queue_count
);
  import chq_pkg::*;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int BW    = $clog2(NUM_BLOCKS);
  localparam int OW    = $clog2(BLOCK_CHARS);
  localparam int DEPTH = NUM_BLOCKS * BLOCK_CHARS;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(NUM_BLOCKS + 1);
  localparam int MW    = (QSEL_W > $clog2(NUM_QUEUES + 1)) ? QSEL_W : $clog2(NUM_QUEUES + 1);
  localparam int WRAPS = (1 << QSEL_W) - 1;
  localparam logic [OW-1:0] LAST_OFF = OW'(BLOCK_CHARS - 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  function automatic logic [AW-1:0] pos_of(input logic [BW-1:0] blk, input logic [OW-1:0] off);
    pos_of = AW'(blk) * AW'(BLOCK_CHARS) + AW'(off);
  endfunction

  state_t            state_r, state_nxt;
  logic [KIND_W-1:0] op_kind_r;
  logic [QW-1:0]     op_q_r;
  logic [BYTE_W-1:0] op_byte_r;

  logic [BW-1:0] head_blk_r [NUM_QUEUES];
  logic [OW-1:0] head_off_r [NUM_QUEUES];
  logic [BW-1:0] tail_blk_r [NUM_QUEUES];
  logic [OW-1:0] tail_off_r [NUM_QUEUES];
  logic [FW-1:0] fill_r     [NUM_QUEUES];
  logic [BW-1:0] head_blk_nxt, tail_blk_nxt;
  logic [OW-1:0] head_off_nxt, tail_off_nxt;
  logic [FW-1:0] fill_nxt;
  logic          qstate_we;

  logic [BW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic [MW-1:0] sel_wrap;
  logic [QW-1:0] in_q;
  logic          in_fire, exec_go, init_done;

  logic          link_rd_en, link_we;
  logic [BW-1:0] link_rd_addr, link_rd_data, link_wr_addr, link_wr_data;
  logic          char_rd_en, char_we;
  logic [AW-1:0] char_rd_addr, char_wr_addr;
  logic [BYTE_W-1:0] char_rd_data;

  logic [FW-1:0] cur_fill;
  logic          need_blk;

  always_comb begin
    sel_wrap = MW'(in_queue_select);
    for (int i = 0; i < WRAPS; i++) begin
      if (sel_wrap >= MW'(NUM_QUEUES)) begin
        sel_wrap = sel_wrap - MW'(NUM_QUEUES);
      end
    end
  end
  assign in_q = sel_wrap[QW-1:0];

  assign in_ready = (state_r == S_IDLE) && init_done;
  assign in_fire  = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign link_rd_en   = in_fire;
  assign link_rd_addr = (in_kind == KIND_PUT) ? free_head_r : head_blk_r[in_q];
  assign char_rd_en   = in_fire && (in_kind == KIND_GET);
  assign char_rd_addr = pos_of(head_blk_r[in_q], head_off_r[in_q]);

  assign cur_fill = fill_r[op_q_r];
  assign need_blk = (cur_fill == '0) || (tail_off_r[op_q_r] == LAST_OFF);

  always_comb begin
    state_nxt      = state_r;
    head_blk_nxt   = head_blk_r[op_q_r];
    head_off_nxt   = head_off_r[op_q_r];
    tail_blk_nxt   = tail_blk_r[op_q_r];
    tail_off_nxt   = tail_off_r[op_q_r];
    fill_nxt       = cur_fill;
    qstate_we      = 1'b0;
    free_head_nxt  = free_head_r;
    free_cnt_nxt   = free_cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    link_we        = 1'b0;
    link_wr_addr   = tail_blk_r[op_q_r];
    link_wr_data   = free_head_r;
    char_we        = 1'b0;
    char_wr_addr   = pos_of(tail_blk_r[op_q_r], tail_off_r[op_q_r] + OW'(1));

    if (in_fire) begin
      state_nxt = S_EXEC;
    end

    if (exec_go) begin
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = '0;
      out_status_nxt = ST_OK;
      if (op_kind_r == KIND_PUT) begin
        if (need_blk && (free_cnt_r == '0)) begin
          out_status_nxt = ST_NOSPACE;
        end else begin
          qstate_we = 1'b1;
          char_we   = 1'b1;
          fill_nxt  = cur_fill + FW'(1);
          if (need_blk) begin
            free_cnt_nxt  = free_cnt_r - CW'(1);
            free_head_nxt = link_rd_data;
            tail_blk_nxt  = free_head_r;
            tail_off_nxt  = '0;
            char_wr_addr  = pos_of(free_head_r, '0);
            if (cur_fill == '0) begin
              head_blk_nxt = free_head_r;
              head_off_nxt = '0;
            end else begin
              link_we = 1'b1;
            end
          end else begin
            tail_off_nxt = tail_off_r[op_q_r] + OW'(1);
          end
        end
      end else begin
        if (cur_fill == '0) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          qstate_we    = 1'b1;
          out_byte_nxt = char_rd_data;
          fill_nxt     = cur_fill - FW'(1);
          link_wr_addr = head_blk_r[op_q_r];
          link_wr_data = (free_cnt_r == '0) ? '0 : free_head_r;
          if (cur_fill == FW'(1)) begin
            link_we       = 1'b1;
            free_head_nxt = head_blk_r[op_q_r];
            free_cnt_nxt  = free_cnt_r + CW'(1);
            head_blk_nxt  = '0;
            head_off_nxt  = '0;
            tail_blk_nxt  = '0;
            tail_off_nxt  = '0;
          end else if (head_off_r[op_q_r] == LAST_OFF) begin
            link_we       = 1'b1;
            free_head_nxt = head_blk_r[op_q_r];
            free_cnt_nxt  = free_cnt_r + CW'(1);
            head_blk_nxt  = link_rd_data;
            head_off_nxt  = '0;
          end else begin
            head_off_nxt = head_off_r[op_q_r] + OW'(1);
          end
        end
      end
      out_count_nxt = COUNT_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      free_cnt_r   <= CW'(NUM_BLOCKS);
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_blk_r[i] <= '0;
        head_off_r[i] <= '0;
        tail_blk_r[i] <= '0;
        tail_off_r[i] <= '0;
        fill_r[i]     <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      free_cnt_r   <= free_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      if (qstate_we) begin
        head_blk_r[op_q_r] <= head_blk_nxt;
        head_off_r[op_q_r] <= head_off_nxt;
        tail_blk_r[op_q_r] <= tail_blk_nxt;
        tail_off_r[op_q_r] <= tail_off_nxt;
        fill_r[op_q_r]     <= fill_nxt;
      end
    end
    if (in_fire) begin
      op_kind_r <= in_kind;
      op_q_r    <= in_q;
      op_byte_r <= in_put_byte;
    end
    out_byte_r  <= out_byte_nxt;
    out_count_r <= out_count_nxt;
  end

  chq_link_mem #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BW         (BW)
  ) u_link_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (link_rd_en),
    .rd_addr   (link_rd_addr),
    .rd_data   (link_rd_data),
    .wr_en     (link_we),
    .wr_addr   (link_wr_addr),
    .wr_data   (link_wr_data),
    .init_done (init_done)
  );

  chq_char_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_char_mem (
    .clk     (clk),
    .rd_en   (char_rd_en),
    .rd_addr (char_rd_addr),
    .rd_data (char_rd_data),
    .wr_en   (char_we),
    .wr_addr (char_wr_addr),
    .wr_data (op_byte_r)
  );

  assign out_valid       = out_valid_r;
  assign out_got_byte    = out_byte_r;
  assign out_status      = out_status_r;
  assign out_queue_count = out_count_r;

  `ASSERT_PROP(a_one_in_flight, in_valid && in_ready |=> !in_ready, "accepted while busy")
  `ASSERT_PROP(a_free_cnt_bound, free_cnt_r <= CW'(NUM_BLOCKS), "free count above pool size")
  `ASSERT_PROP(a_empty_result, out_valid && out_status == ST_EMPTY |-> out_got_byte == '0 && out_queue_count == '0, "empty get with data")

endmodule

### verif/tb_linked_block_char_queue.sv
module tb_linked_block_char_queue;
  import chq_pkg::*;

  localparam int NQ         = 4;
  localparam int NB         = 64;
  localparam int BC         = 6;
  localparam int DEPTH      = NB * BC;
  localparam int STALL_MAX  = 4000;
  localparam int N_DIR      = 25;

  typedef struct packed {
    logic [BYTE_W-1:0]  got;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } chq_result_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [QSEL_W-1:0]  qsel;
    logic [BYTE_W-1:0]  data;
    bit                 typed;
    logic [BYTE_W-1:0]  got;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  logic [QSEL_W-1:0]   in_queue_select;
  logic [BYTE_W-1:0]   in_put_byte;
  logic                out_valid;
  logic                out_ready;
  logic [BYTE_W-1:0]   out_got_byte;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_queue_count;

  // shadow copy of the block pool
  logic [7:0]  store_mem [DEPTH];
  int          link_mem  [NB];
  int          free_head;
  int          free_cnt;
  int          head_pos  [NQ];
  int          tail_pos  [NQ];
  int          fill      [NQ];

  chq_result_t op_outcomes [$];
  chq_result_t head_outcome;
  int          mismatches;
  int          stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  dir_row_t dir_rows [N_DIR] = '{
    '{KIND_GET, 2'd0, 8'h00, 1'b1, 8'h00, ST_EMPTY, 9'd0},
    '{KIND_GET, 2'd3, 8'hff, 1'b1, 8'h00, ST_EMPTY, 9'd0},
    '{KIND_PUT, 2'd0, 8'h00, 1'b1, 8'h00, ST_OK,    9'd1},
    '{KIND_PUT, 2'd0, 8'hff, 1'b1, 8'h00, ST_OK,    9'd2},
    '{KIND_PUT, 2'd1, 8'ha5, 1'b1, 8'h00, ST_OK,    9'd1},
    '{KIND_GET, 2'd0, 8'h5a, 1'b1, 8'h00, ST_OK,    9'd1},
    '{KIND_GET, 2'd0, 8'h00, 1'b1, 8'hff, ST_OK,    9'd0},
    '{KIND_GET, 2'd0, 8'h00, 1'b1, 8'h00, ST_EMPTY, 9'd0},
    '{KIND_PUT, 2'd2, 8'h55, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'haa, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'h01, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'h02, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'h04, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'h80, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'h7f, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_PUT, 2'd2, 8'hfe, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b0, 8'h00, ST_OK,    9'd0},
    '{KIND_GET, 2'd2, 8'h00, 1'b1, 8'h00, ST_EMPTY, 9'd0}
  };

  linked_block_char_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_queue_select (in_queue_select),
    .in_put_byte     (in_put_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_got_byte    (out_got_byte),
    .out_status      (out_status),
    .out_queue_count (out_queue_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int take_block();
    int b;
    b = free_head;
    free_cnt--;
    if (free_cnt == 0) free_head = NB;
    else free_head = link_mem[b % NB] % NB;
    return b % NB;
  endfunction

  function automatic void give_block(int b);
    b = b % NB;
    link_mem[b] = (free_cnt == 0) ? 0 : free_head;
    free_head = b;
    free_cnt++;
  endfunction

  function automatic chq_result_t predict_char_op(logic [KIND_W-1:0] kind,
                                                  logic [QSEL_W-1:0] qsel,
                                                  logic [BYTE_W-1:0] data);
    chq_result_t r;
    int          qi;
    int          pos;
    int          blk;
    int          nxt;
    bit          need;
    qi = int'(qsel) % NQ;
    r.got = '0;
    r.status = ST_OK;
    if (kind == KIND_PUT) begin
      need = (fill[qi] == 0) || (tail_pos[qi] % BC == BC - 1);
      if (need && free_cnt == 0) begin
        r.status = ST_NOSPACE;
      end else begin
        if (fill[qi] == 0) begin
          pos = take_block() * BC;
          head_pos[qi] = pos;
        end else if (need) begin
          blk = take_block();
          link_mem[(tail_pos[qi] / BC) % NB] = blk;
          pos = blk * BC;
        end else begin
          pos = tail_pos[qi] + 1;
        end
        pos = pos % DEPTH;
        store_mem[pos] = data;
        tail_pos[qi] = pos;
        fill[qi]++;
      end
    end else if (fill[qi] == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pos = head_pos[qi] % DEPTH;
      blk = pos / BC;
      r.got = store_mem[pos];
      fill[qi]--;
      if (fill[qi] == 0) begin
        give_block(blk);
        head_pos[qi] = 0;
        tail_pos[qi] = 0;
      end else if (pos % BC == BC - 1) begin
        nxt = link_mem[blk] % NB;
        give_block(blk);
        head_pos[qi] = nxt * BC;
      end else begin
        head_pos[qi] = pos + 1;
      end
    end
    r.count = COUNT_W'(fill[qi]);
    return r;
  endfunction

  task automatic drive_op(input logic [KIND_W-1:0] kind, input logic [QSEL_W-1:0] qsel,
                          input logic [BYTE_W-1:0] data, input bit typed,
                          input chq_result_t typed_res);
    chq_result_t pred;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_queue_select <= qsel;
    in_put_byte     <= data;
    do @(posedge clk); while (!in_ready);
    pred = predict_char_op(kind, qsel, data);
    op_outcomes.push_back(typed ? typed_res : pred);
  endtask

  task automatic drive_random(input int put_pct);
    drive_op(($urandom_range(99) < put_pct) ? KIND_PUT : KIND_GET,
             QSEL_W'($urandom_range(3)), BYTE_W'($urandom_range(255)), 1'b0, '0);
  endtask

  // sender holds off until the block has answered everything
  task automatic wait_all_answered();
    in_valid <= 1'b0;
    do @(posedge clk); while (op_outcomes.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (op_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transaction: got=%0h status=%0d count=%0d",
                     out_got_byte, out_status, out_queue_count);
          mismatches++;
        end else begin
          head_outcome = op_outcomes.pop_front();
          if (out_got_byte !== head_outcome.got || out_status !== head_outcome.status ||
              out_queue_count !== head_outcome.count) begin
            if (mismatches < 10)
              $display("exp got=%0h st=%0d cnt=%0d, act got=%0h st=%0d cnt=%0d",
                       head_outcome.got, head_outcome.status, head_outcome.count,
                       out_got_byte, out_status, out_queue_count);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("linked_block_char_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int i;
    chq_result_t row_res;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_kind         = KIND_PUT;
    in_queue_select = '0;
    in_put_byte     = '0;
    out_ready       = 1'b0;
    mismatches      = 0;
    stall_cycles    = 0;
    send_idle_pct   = 21;
    recv_idle_pct   = 60;
    for (i = 0; i < DEPTH; i++) store_mem[i] = '0;
    for (i = 0; i < NB; i++) link_mem[i] = (i + 1) % NB;
    free_head = 0;
    free_cnt  = NB;
    for (i = 0; i < NQ; i++) begin
      head_pos[i] = 0;
      tail_pos[i] = 0;
      fill[i]     = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      row_res.got    = dir_rows[i].got;
      row_res.status = dir_rows[i].status;
      row_res.count  = dir_rows[i].count;
      drive_op(dir_rows[i].kind, dir_rows[i].qsel, dir_rows[i].data, dir_rows[i].typed,
               row_res);
    end
    wait_all_answered();

    for (i = 0; i < 60; i++) drive_random(55);

    send_idle_pct = 60;
    recv_idle_pct = 21;
    // run the pool dry, then probe no-space and tail-block puts
    while (free_cnt > 0) drive_random(100);
    for (i = 0; i < 16; i++) drive_random(100);
    wait_all_answered();
    for (i = 0; i < NQ; i++) begin
      while (fill[i] != 0) drive_op(KIND_GET, QSEL_W'(i), 8'h00, 1'b0, '0);
    end
    for (i = 0; i < 4; i++) drive_op(KIND_GET, QSEL_W'(i), 8'h00, 1'b0, '0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < 60; i++) drive_random(50);
    for (i = 0; i < 40; i++) drive_random(90);
    for (i = 0; i < 40; i++) drive_random(20);

    in_valid <= 1'b0;
    while (op_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && op_outcomes.size() == 0) begin
      $display("linked_block_char_queue: match");
    end else begin
      $display("linked_block_char_queue: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/chq_pkg.sv
hdl/chq_char_mem.sv
hdl/chq_link_mem.sv
hdl/linked_block_char_queue.sv
verif/tb_linked_block_char_queue.sv
